// ----- src/selection_hit_recorder_assert.svh -----
// ---------------------------------------------------------------------------
// selection_hit_recorder_assert.svh
// Assertion macros for the selection hit recorder, all clocked on clk
// and held off during rst.
// ---------------------------------------------------------------------------
`ifndef SELECTION_HIT_RECORDER_ASSERT_SVH
`define SELECTION_HIT_RECORDER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SHR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("selection_hit_recorder: assertion failed");

// next-cycle implication
`define SHR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("selection_hit_recorder: assertion failed");

`else

`define SHR_ASSERT_NOW(label, ante, cons)
`define SHR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/shr_pkg.sv -----
// ---------------------------------------------------------------------------
// shr_pkg
// Types, codes and the depth mapping shared by the selection hit recorder.
// ---------------------------------------------------------------------------
package shr_pkg;

  typedef enum logic [2:0] {
    CMD_SET_ENABLE    = 3'd0,
    CMD_INIT_NAMES    = 3'd1,
    CMD_PUSH_NAME     = 3'd2,
    CMD_POP_NAME      = 3'd3,
    CMD_LOAD_NAME     = 3'd4,
    CMD_PRIMITIVE_HIT = 3'd5
  } cmd_t;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_COUNT  = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic               enable_flag;
    logic [31:0]        name_value;
    logic signed [31:0] depth_near;
    logic signed [31:0] depth_far;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  slot;
    logic [6:0]  name_count;
    logic [31:0] depth_min;
    logic [31:0] depth_max;
    logic [31:0] top_name;
    logic [8:0]  hit_count;
    logic        last;
  } result_t;

  // Q2.30 in -1..1 to unsigned 32-bit depth, saturating.
  // t = x + 1.0; result = 2t - 1 for t in (0, 2^31], approximating t * (2^32-1) / 2^31.
  function automatic logic [31:0] map_depth(input logic signed [31:0] x);
    logic signed [33:0] t;
    t = 34'(x) + 34'sh0_4000_0000;
    if (t <= 34'sd0) begin
      map_depth = 32'd0;
    end else if (t > 34'sh0_8000_0000) begin
      map_depth = 32'hFFFF_FFFF;
    end else begin
      map_depth = {t[30:0], 1'b0} - 32'd1;
    end
  endfunction

endpackage

// ----- src/selection_hit_recorder.sv -----
// ---------------------------------------------------------------------------
// selection_hit_recorder
// Selection-mode hit recorder: name stack, one open hit record, record
// count, emitting written records and count replies.
// ---------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    cmd, enable_flag, name_value, depth_near, depth_far
//  out      out_valid / out_stall  kind, slot, name_count, depth_min, depth_max,
//                                  top_name, hit_count, last
//  cfg      cfg_valid / cfg_ready  cfg_data (buffer_records)
//
//  One command per cycle while in_stall is low: an accepted beat is held in the input
//  register, then executes and its results land in a 4-entry output queue. set_enable
//  can yield two result beats; the out port moves one per cycle while out_stall is low.
//  A command waits in the input register while the queue has fewer than two free
//  entries. Top of stack is read from the name RAM ahead of use, by a registered read.
//  rst is synchronous; cfg_ready is always high.
// ---------------------------------------------------------------------------
`include "selection_hit_recorder_assert.svh"

module selection_hit_recorder #(
  parameter int STACK_DEPTH = 64,
  parameter int MAX_RECORDS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic               enable_flag,
  input  logic [31:0]        name_value,
  input  logic signed [31:0] depth_near,
  input  logic signed [31:0] depth_far,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [7:0]         slot,
  output logic [6:0]         name_count,
  output logic [31:0]        depth_min,
  output logic [31:0]        depth_max,
  output logic [31:0]        top_name,
  output logic [8:0]         hit_count,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data
);
  import shr_pkg::*;

  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SW-1:0] STACK_FULL = SW'(STACK_DEPTH);
  localparam logic [16:0] MAX_REC = 17'(MAX_RECORDS);

  // configuration
  logic [8:0] buffer_records;
  logic [8:0] limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_records <= '0;
    end else if (cfg_valid) begin
      buffer_records <= cfg_data;
    end
  end

  assign limit = (17'(buffer_records) < MAX_REC) ? buffer_records : MAX_REC[8:0];

  // input register
  item_t in_q;
  logic  in_q_valid;
  logic  exec;
  logic [FIFO_CW-1:0] fifo_count;

  assign exec     = in_q_valid && (fifo_count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign in_stall = in_q_valid && !exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q.cmd         <= cmd;
      in_q.enable_flag <= enable_flag;
      in_q.name_value  <= name_value;
      in_q.depth_near  <= depth_near;
      in_q.depth_far   <= depth_far;
    end
  end

  // architectural state
  logic          select_enabled, select_enabled_next;
  logic [SW-1:0] stack_size, stack_size_next;
  logic [8:0]    records_written, records_written_next;
  logic [31:0]   open_near, open_near_next;
  logic [31:0]   open_far, open_far_next;
  logic [SW-1:0] open_count, open_count_next;
  logic [31:0]   open_name, open_name_next;

  // name RAM
  logic [31:0]   name_store [STACK_DEPTH];
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [31:0]   rd_data;
  logic          byp;
  logic [31:0]   byp_data;
  logic [31:0]   stack_top;
  logic [SW-1:0] size_m1;
  logic [SW-1:0] size_next_m1;

  always_ff @(posedge clk) begin
    if (we) begin
      name_store[waddr] <= in_q.name_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= name_store[raddr];
  end

  // write-first forwarding for a write to the address being read
  always_ff @(posedge clk) begin
    byp      <= we && (waddr == raddr);
    byp_data <= in_q.name_value;
  end

  assign stack_top    = byp ? byp_data : rd_data;
  assign size_m1      = stack_size - SW'(1);
  assign size_next_m1 = stack_size_next - SW'(1);
  assign raddr        = size_next_m1[AW-1:0];

  // execute
  logic        do_close;
  logic        do_reply;
  logic        emit;
  logic [31:0] near_map, far_map;
  result_t     rec, reply;
  result_t     res0;
  logic [1:0]  n_push;

  assign near_map = map_depth(in_q.depth_near);
  assign far_map  = map_depth(in_q.depth_far);
  assign emit     = (open_near <= open_far) && (records_written < limit);

  always_comb begin
    select_enabled_next  = select_enabled;
    stack_size_next      = stack_size;
    records_written_next = records_written;
    open_near_next       = open_near;
    open_far_next        = open_far;
    open_count_next      = open_count;
    open_name_next       = open_name;
    we                   = 1'b0;
    waddr                = stack_size[AW-1:0];
    do_close             = 1'b0;
    do_reply             = 1'b0;

    if (exec) begin
      unique case (cmd_t'(in_q.cmd))
        CMD_SET_ENABLE: begin
          select_enabled_next = in_q.enable_flag;
          do_close            = 1'b1;
          do_reply            = 1'b1;
        end
        CMD_INIT_NAMES: begin
          if (select_enabled) begin
            stack_size_next = '0;
            do_close        = 1'b1;
          end
        end
        CMD_PUSH_NAME: begin
          if (select_enabled) begin
            if (stack_size < STACK_FULL) begin
              we              = 1'b1;
              stack_size_next = stack_size + SW'(1);
            end
            do_close = 1'b1;
          end
        end
        CMD_POP_NAME: begin
          if (select_enabled) begin
            if (stack_size != '0) begin
              stack_size_next = size_m1;
            end
            do_close = 1'b1;
          end
        end
        CMD_LOAD_NAME: begin
          if (select_enabled) begin
            we = 1'b1;
            if (stack_size != '0) begin
              waddr = size_m1[AW-1:0];
            end else begin
              stack_size_next = SW'(1);
            end
            do_close = 1'b1;
          end
        end
        CMD_PRIMITIVE_HIT: begin
          if (near_map < open_near) begin
            open_near_next = near_map;
          end
          if (far_map > open_far) begin
            open_far_next = far_map;
          end
          open_count_next = stack_size;
          open_name_next  = (stack_size != '0) ? stack_top : 32'd0;
        end
        default: begin
        end
      endcase
    end

    if (do_close) begin
      if (emit) begin
        records_written_next = records_written + 9'd1;
      end
      open_near_next  = 32'hFFFF_FFFF;
      open_far_next   = 32'd0;
      open_count_next = '0;
      open_name_next  = 32'd0;
    end
    if (do_reply) begin
      records_written_next = '0;
    end
  end

  always_comb begin
    rec            = '0;
    rec.kind       = KIND_RECORD;
    rec.slot       = records_written[7:0];
    rec.name_count = 7'(open_count);
    rec.depth_min  = open_near;
    rec.depth_max  = open_far;
    rec.top_name   = open_name;
    rec.last       = !do_reply;

    reply           = '0;
    reply.kind      = KIND_COUNT;
    reply.hit_count = records_written + 9'(emit);
    reply.last      = 1'b1;

    res0   = (do_close && emit) ? rec : reply;
    n_push = 2'(do_close && emit) + 2'(do_reply);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      select_enabled  <= 1'b0;
      stack_size      <= '0;
      records_written <= '0;
      open_near       <= 32'hFFFF_FFFF;
      open_far        <= '0;
      open_count      <= '0;
      open_name       <= '0;
    end else begin
      select_enabled  <= select_enabled_next;
      stack_size      <= stack_size_next;
      records_written <= records_written_next;
      open_near       <= open_near_next;
      open_far        <= open_far_next;
      open_count      <= open_count_next;
      open_name       <= open_name_next;
    end
  end

  // output queue
  result_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW-1:0] wptr_p1;
  logic               pop;
  result_t            head;

  assign wptr_p1   = wptr + FIFO_AW'(1);
  assign out_valid = (fifo_count != '0);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_mem[wptr] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_mem[wptr_p1] <= reply;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr       <= '0;
      rptr       <= '0;
      fifo_count <= '0;
    end else begin
      wptr       <= wptr + FIFO_AW'(n_push);
      rptr       <= rptr + FIFO_AW'(pop);
      fifo_count <= fifo_count + FIFO_CW'(n_push) - FIFO_CW'(pop);
    end
  end

  assign head       = fifo_mem[rptr];
  assign kind       = head.kind;
  assign slot       = head.slot;
  assign name_count = head.name_count;
  assign depth_min  = head.depth_min;
  assign depth_max  = head.depth_max;
  assign top_name   = head.top_name;
  assign hit_count  = head.hit_count;
  assign last       = head.last;

  // checks
  `SHR_ASSERT_NOW(a_stack_bound, 1'b1, stack_size <= STACK_FULL)
  `SHR_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_count <= FIFO_CW'(FIFO_DEPTH))
  `SHR_ASSERT_NEXT(a_reply_clears, exec && in_q.cmd == CMD_SET_ENABLE, records_written == '0)
  `SHR_ASSERT_NEXT(a_disabled_stack, exec && !select_enabled && in_q.cmd != CMD_SET_ENABLE, $stable(stack_size) && $stable(select_enabled))
  `SHR_ASSERT_NEXT(a_held_item, in_stall, in_q_valid && $stable(in_q))

endmodule
